### hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Holds the controller states, the command/status bundles between the
// controller and the datapath, operation codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  // Default built depth of the cache
  localparam int DEF_MAX_ENTRIES = 16;

  // Fixed field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Capacity register value after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESOLVE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input word, restart the search
    logic scan;    // read the entry at the scan index, advance
    logic commit;  // apply the update and load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last entry
    logic out_free;   // result register can take a new word this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl: operation sequencer for the LRU key-value cache
// Accepts one word, sweeps every entry once, then commits the update and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lkv_pkg::dp_stat_t stat,
  output lkv_pkg::ctrl_cmd_t     cmd
);

  import lkv_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // last entry is being checked this cycle
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // hold until the result register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/lkv_dpath.sv
// ----------------------------------------------------------------------------
// lkv_dpath: storage, search and update datapath of the LRU key-value cache
// Keys and values live in a RAM that is swept one entry a cycle; valid
// bits, recency ranks and occupancy live in flops and update in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_dpath #(
  parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lkv_pkg::ctrl_cmd_t           cmd,
  output lkv_pkg::dp_stat_t                 stat,
  input  wire logic                         in_cmd,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lkv_pkg::VAL_W-1:0] in_write_value,
  input  wire logic                         cfg_we,
  input  wire logic [lkv_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0]  out_read_value
);

  import lkv_pkg::*;

  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (OW > CFG_W) ? OW : CFG_W;
  localparam int DW   = KEY_W + VAL_W;

  // Configuration and item registers
  logic [CFG_W-1:0] cap_r;
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // Scan pipeline
  logic [IW-1:0]    scan_idx_r;
  logic             chk_vld_r;
  logic [IW-1:0]    chk_idx_r;
  logic [DW-1:0]    rd_data;

  // Search results
  logic             found_r;
  logic [IW-1:0]    match_r;
  logic [VAL_W-1:0] hit_val_r;
  logic             have_free_r;
  logic [IW-1:0]    free_r;
  logic             have_lru_r;
  logic [IW-1:0]    lru_r;

  // Entry state
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [IW-1:0]          rank_r   [MAX_ENTRIES];
  logic [IW-1:0]          rank_nxt [MAX_ENTRIES];
  logic [OW-1:0]          occ_r;
  logic [OW-1:0]          occ_nxt;
  logic [OW-1:0]          occ_m1;

  // Result register
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic signed [VAL_W-1:0] out_read_value_r;

  // Update decode
  logic             do_touch;
  logic             do_fill;
  logic [IW-1:0]    touch_idx;
  logic [IW-1:0]    touch_rank;
  logic             ram_we;
  logic [IW-1:0]    ram_wr_addr;
  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  max_ext;
  logic [CMPW-1:0]  cap_eff;
  logic [CMPW-1:0]  occ_ext;
  logic             chk_valid;
  logic             chk_key_eq;
  logic             chk_is_lru;

  // Key/value store
  lkv_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_kv_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data ({key_r, val_r}),
    .re      (cmd.scan),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  // Capacity clamped to the built depth
  always_comb begin
    cap_ext = CMPW'(cap_r);
    max_ext = CMPW'(MAX_ENTRIES);
    cap_eff = (cap_ext > max_ext) ? max_ext : cap_ext;
    occ_ext = CMPW'(occ_r);
    occ_m1  = occ_r - 1'b1;
  end

  // Check the entry coming out of the RAM
  always_comb begin
    chk_valid  = valid_r[chk_idx_r];
    chk_key_eq = (rd_data[DW-1:VAL_W] == key_r);
    chk_is_lru = (OW'(rank_r[chk_idx_r]) == occ_m1);
  end

  // Decide the update for this operation
  always_comb begin
    do_touch    = 1'b0;
    do_fill     = 1'b0;
    touch_idx   = match_r;
    ram_we      = 1'b0;
    ram_wr_addr = match_r;
    if (cmd.commit) begin
      if (found_r) begin
        do_touch    = 1'b1;
        ram_we      = (cmd_r == CMD_PUT);
      end else if (cmd_r == CMD_PUT) begin
        if (cap_eff == '0) begin
          // zero capacity: drop the new key
          do_fill = 1'b0;
        end else if ((occ_ext < cap_eff) && have_free_r) begin
          do_fill     = 1'b1;
          ram_we      = 1'b1;
          ram_wr_addr = free_r;
        end else if (have_lru_r) begin
          do_touch    = 1'b1;
          touch_idx   = lru_r;
          ram_we      = 1'b1;
          ram_wr_addr = lru_r;
        end
      end
    end
    touch_rank = rank_r[touch_idx];
  end

  // Age ranks and mark the filled entry, one lane per entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i]  = rank_r[i];
      valid_nxt[i] = valid_r[i];
      if (do_touch) begin
        if (IW'(i) == touch_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < touch_rank)) begin
          rank_nxt[i] = IW'(rank_r[i] + 1'b1);
        end
      end
      if (do_fill) begin
        if (valid_r[i]) begin
          rank_nxt[i] = IW'(rank_r[i] + 1'b1);
        end else if (IW'(i) == free_r) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end
      end
    end
    occ_nxt = occ_r + OW'(do_fill);
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      key_r <= in_lookup_key;
      val_r <= in_write_value;
    end
  end

  // Capture search payloads
  always_ff @(posedge clk) begin
    if (chk_vld_r && chk_valid && !found_r && chk_key_eq) begin
      match_r   <= chk_idx_r;
      hit_val_r <= rd_data[VAL_W-1:0];
    end
    if (chk_vld_r && chk_valid && chk_is_lru) begin
      lru_r <= chk_idx_r;
    end
    if (chk_vld_r && !chk_valid && !have_free_r) begin
      free_r <= chk_idx_r;
    end
    chk_idx_r <= scan_idx_r;
  end

  // Scan control and search flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      have_free_r <= 1'b0;
      have_lru_r  <= 1'b0;
    end else begin
      chk_vld_r <= cmd.scan;
      if (cmd.load) begin
        scan_idx_r  <= '0;
        found_r     <= 1'b0;
        have_free_r <= 1'b0;
        have_lru_r  <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx_r <= IW'(scan_idx_r + 1'b1);
        end
        if (chk_vld_r && chk_valid && chk_key_eq) begin
          found_r <= 1'b1;
        end
        if (chk_vld_r && chk_valid && chk_is_lru) begin
          have_lru_r <= 1'b1;
        end
        if (chk_vld_r && !chk_valid) begin
          have_free_r <= 1'b1;
        end
      end
    end
  end

  // Entry state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r        <= found_r;
      out_read_value_r <= ((cmd_r == CMD_GET) && found_r) ? hit_val_r : '0;
    end
  end

  always_comb begin
    stat.scan_last = (scan_idx_r == IW'(MAX_ENTRIES - 1));
    stat.out_free  = !out_valid_r || out_ready;
    out_valid      = out_valid_r;
    out_hit        = out_hit_r;
    out_read_value = out_read_value_r;
  end

`ifndef SYNTHESIS
  // Occupancy tracks the number of valid entries
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == occ_r)
    else $error("occupancy differs from valid entry count");

  // Occupancy never exceeds the built depth
  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_ext <= max_ext)
    else $error("occupancy above built depth");

  // A commit always produces a result word
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not load the result register");

  // A get never changes occupancy
  a_get_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (cmd_r == CMD_GET)) |=> $stable(occ_r))
    else $error("get changed occupancy");
`endif

endmodule

`default_nettype wire

### hdl/lru_key_value_cache.sv
// Each accepted word sweeps every entry of the key/value RAM through its single
// read port, then commits its update and loads the result register; a new word
// is not accepted until that commit, which waits while an older result is untaken.
// The next word is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) empties the cache and sets capacity 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Get returns the stored value on a hit; put overwrites, fills a free entry or
// replaces the LRU one; zero capacity drops new keys. Controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_cmd,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lkv_pkg::VAL_W-1:0] in_write_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0]      out_read_value,
  input  wire logic                             cfg_we,
  input  wire logic [lkv_pkg::CFG_W-1:0]        cfg_wdata
);

  import lkv_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and update datapath
  lkv_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

endmodule

`default_nettype wire

### tb/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Drives get/put words through the valid/ready input, mirrors the cache in a
// behavioral LRU table and checks every hit flag and read value in order.
// Covers empty lookups, overwrites, shrinking, zero and clamped capacity,
// then random traffic over a small key pool under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int DEPTH        = DEF_MAX_ENTRIES;
  localparam int LATENCY      = DEPTH + 3;
  localparam int MAX_WAIT     = 13;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 60;
  localparam int POOL_SIZE    = 32;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] value;
  } lookup_result_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic                    in_cmd         = CMD_GET;
  logic signed [KEY_W-1:0] in_lookup_key  = '0;
  logic signed [VAL_W-1:0] in_write_value = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_we         = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata      = '0;

  // Behavioral copy of the cache contents
  logic signed [KEY_W-1:0] line_key   [DEPTH];
  logic signed [VAL_W-1:0] line_value [DEPTH];
  bit                      line_valid [DEPTH];
  int unsigned             line_age   [DEPTH];
  int unsigned             lines_used;
  int unsigned             capacity;

  // Results still owed by the cache, oldest first
  lookup_result_t          pending_lookups[$];

  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  bit                      no_idle;
  int unsigned             mismatches;
  int unsigned             words_sent;
  int unsigned             results_seen;
  int unsigned             hit_count;
  int unsigned             evictions;
  int unsigned             dropped_puts;
  int unsigned             cap_writes;
  int unsigned             cycle_count;

  lru_key_value_cache #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_lookup_key (in_lookup_key),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_lookups.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Make line e newest: every valid line younger than it ages by one
  function automatic void make_newest(int unsigned e);
    int unsigned r;
    r = line_age[e];
    for (int i = 0; i < DEPTH; i++) begin
      if (line_valid[i] && i != e && line_age[i] < r) line_age[i]++;
    end
    line_age[e] = 0;
  endfunction

  function automatic lookup_result_t cache_access(logic cmd, logic signed [KEY_W-1:0] key,
                                                  logic signed [VAL_W-1:0] value);
    int unsigned    cap_eff;
    int unsigned    match;
    int unsigned    free_line;
    int unsigned    oldest;
    int unsigned    oldest_age;
    bit             found;
    bit             have_free;
    bit             have_oldest;
    lookup_result_t res;
    cap_eff     = (capacity > DEPTH) ? DEPTH : capacity;
    match       = 0;
    free_line   = 0;
    oldest      = 0;
    oldest_age  = 0;
    found       = 1'b0;
    have_free   = 1'b0;
    have_oldest = 1'b0;
    // Search for the key, the first free line and the oldest line
    for (int i = 0; i < DEPTH; i++) begin
      if (line_valid[i]) begin
        if (!found && line_key[i] == key) begin
          found = 1'b1;
          match = i;
        end
        if (!have_oldest || line_age[i] > oldest_age) begin
          have_oldest = 1'b1;
          oldest      = i;
          oldest_age  = line_age[i];
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_line = i;
      end
    end
    res.hit   = found;
    res.value = '0;
    if (found) hit_count++;
    if (cmd == CMD_GET) begin
      if (found) begin
        res.value = line_value[match];
        make_newest(match);
      end
    end else if (found) begin
      line_value[match] = value;
      make_newest(match);
    end else if (cap_eff == 0) begin
      dropped_puts++;
    end else if (lines_used < cap_eff && have_free) begin
      // Fill a free line as the newest
      for (int i = 0; i < DEPTH; i++) begin
        if (line_valid[i]) line_age[i]++;
      end
      line_key[free_line]   = key;
      line_value[free_line] = value;
      line_valid[free_line] = 1'b1;
      line_age[free_line]   = 0;
      lines_used++;
    end else if (have_oldest) begin
      // Replace the oldest line in place
      line_key[oldest]   = key;
      line_value[oldest] = value;
      make_newest(oldest);
      evictions++;
    end
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Shared helpers
  // ------------------------------------------------------------------------

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(string what, logic signed [VAL_W-1:0] got,
                                 logic signed [VAL_W-1:0] want);
    $display("Mismatch on result %0d: %s, got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Present one word after a random gap and hold it until accepted
  task automatic send_word(logic cmd, logic signed [KEY_W-1:0] key,
                           logic signed [VAL_W-1:0] value);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_lookup_key  <= key;
    in_write_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_lookups.push_back(cache_access(cmd, key, value));
    words_sent++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    capacity   = cap;
    cap_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Result side: random stalls, in-order check
  // ------------------------------------------------------------------------

  initial begin
    int stall;
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with nothing expected", out_read_value, '0);
      end else begin
        want = pending_lookups.pop_front();
        if (out_hit !== want.hit)
          report_mismatch("hit flag", VAL_W'(out_hit), VAL_W'(want.hit));
        if (out_read_value !== want.value)
          report_mismatch("read value", out_read_value, want.value);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  task automatic test_empty_lookups();
    send_word(CMD_GET, 32'sd0, 32'sd0);
    send_word(CMD_GET, 32'h8000_0000, 32'h7fff_ffff);
  endtask

  task automatic test_store_and_overwrite();
    send_word(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(CMD_PUT, -32'sd1, -32'sd1);
    send_word(CMD_GET, 32'h8000_0000, 32'sd0);
    send_word(CMD_GET, -32'sd1, 32'sd0);
    // Overwrite a present key
    send_word(CMD_PUT, 32'h8000_0000, 32'sd0);
    send_word(CMD_GET, 32'h8000_0000, -32'sd1);
    send_word(CMD_GET, 32'h7fff_ffff, 32'sd0);
  endtask

  // Capacity below occupancy: new keys replace the oldest line
  task automatic test_shrink_capacity();
    write_capacity(5'd2);
    send_word(CMD_PUT, 32'sd5, 32'sd55);
    send_word(CMD_GET, -32'sd1, 32'sd0);
    send_word(CMD_PUT, 32'sd6, 32'sd66);
    send_word(CMD_GET, 32'sd5, 32'sd0);
  endtask

  // Zero capacity: new keys are dropped, present keys still update
  task automatic test_zero_capacity();
    write_capacity(5'd0);
    send_word(CMD_PUT, 32'sd7, 32'sd70);
    send_word(CMD_GET, 32'sd7, 32'sd0);
    send_word(CMD_PUT, 32'sd5, 32'sd99);
    send_word(CMD_GET, 32'sd5, 32'sd0);
  endtask

  // Capacity above the built depth is clamped
  task automatic test_clamped_capacity();
    write_capacity(5'd31);
    for (int k = 100; k < 105; k++) send_word(CMD_PUT, k, k * 3);
    send_word(CMD_GET, 32'sd100, 32'sd0);
  endtask

  // Random get/put over a key pool sized to force hits and replacements
  task automatic test_random_traffic();
    logic [CFG_W-1:0]        caps [9];
    int unsigned             span;
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8, 5'd2, 5'd16};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      span    = (caps[p] > DEPTH) ? DEPTH + 4 : caps[p] + 4;
      if (span > POOL_SIZE) span = POOL_SIZE;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, span - 1)];
        send_word(cmd, key, $urandom);
        // Pause now and then until the cache has answered everything
        if ($urandom_range(0, 39) == 0) drain();
        if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    // Reset the predictor to an empty cache
    foreach (line_valid[i]) begin
      line_key[i]   = '0;
      line_value[i] = '0;
      line_valid[i] = 1'b0;
      line_age[i]   = 0;
    end
    lines_used = 0;
    capacity   = CAP_RESET;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    no_idle = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lookups();
    test_store_and_overwrite();
    test_shrink_capacity();
    test_zero_capacity();
    test_clamped_capacity();
    test_random_traffic();
    drain();

    if (pending_lookups.size() != 0)
      report_mismatch("results never returned", '0, pending_lookups.size());

    $display("Sent %0d words, checked %0d results: %0d hits, %0d replacements,",
             words_sent, results_seen, hit_count, evictions);
    $display("%0d puts dropped at zero capacity, %0d capacity settings.",
             dropped_puts, cap_writes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/lkv_pkg.sv
hdl/lkv_ram.sv
hdl/lkv_ctrl.sv
hdl/lkv_dpath.sv
hdl/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
